// File: rtl/core/sgaf_pkg.sv
// ----------------------------------------------------------------------------
// sgaf_pkg
// Shared types and constants for the stick gesture arming block.
// ----------------------------------------------------------------------------
package sgaf_pkg;

  localparam int unsigned STICK_W = 11;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 32;

  // register indexes on the config port
  localparam logic [CIDX_W-1:0] CFG_THROTTLE_MAX = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_ROLL_MIN     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_PITCH_MAX    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_YAW_MAX      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ARM_HOLD     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_DISARM_HOLD  = 3'd5;

  // reset values
  localparam logic signed [STICK_W-1:0] RST_THROTTLE_MAX = 11'sd55;
  localparam logic signed [STICK_W-1:0] RST_ROLL_MIN     = 11'sd445;
  localparam logic signed [STICK_W-1:0] RST_PITCH_MAX    = -11'sd445;
  localparam logic signed [STICK_W-1:0] RST_YAW_MAX      = -11'sd445;
  localparam logic [TIME_W-1:0]         RST_ARM_HOLD     = 32'd1000;
  localparam logic [TIME_W-1:0]         RST_DISARM_HOLD  = 32'd1000;

  typedef enum logic [2:0] {
    PH_DISARMED       = 3'd0,
    PH_ARMING         = 3'd1,
    PH_ARM_STANDBY    = 3'd2,
    PH_ARMED          = 3'd3,
    PH_DISARMING      = 3'd4,
    PH_DISARM_STANDBY = 3'd5,
    PH_DEBUG          = 3'd6
  } phase_t;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_DEBUG  = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] throttle_max;
    logic signed [STICK_W-1:0] roll_min;
    logic signed [STICK_W-1:0] pitch_max;
    logic signed [STICK_W-1:0] yaw_max;
    logic [TIME_W-1:0]         arm_hold_ms;
    logic [TIME_W-1:0]         disarm_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] throttle;
    logic signed [STICK_W-1:0] roll;
    logic signed [STICK_W-1:0] pitch;
    logic signed [STICK_W-1:0] yaw;
  } sticks_t;

  // per-item control from the input register into the fsm
  typedef struct packed {
    logic              step;
    kind_t             kind;
    logic              gesture;
    logic [TIME_W-1:0] now_ms;
  } fsm_req_t;

  typedef struct packed {
    phase_t phase;
    logic   is_armed;
  } fsm_res_t;

endpackage

// File: rtl/core/stick_gesture_arming_fsm.sv
// ----------------------------------------------------------------------------
// stick_gesture_arming_fsm
// Remote-control arm / disarm state machine driven by a stick gesture.
// ----------------------------------------------------------------------------
// Each input beat is either a periodic update (four signed stick channels and
// a millisecond timestamp) or a debug request, and yields exactly one output
// beat with the new phase and the armed flag. The block takes one beat per
// clock cycle when the output side is not stalling; a beat passes through
// the input register and then the result register, with the gesture
// compare, the 32-bit elapsed-time compare and the phase update done in the
// single combinational pass between them. Stall propagates back through both
// registers in the same cycle, so a full pipe stalls the input at once.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata,
// and the user must only do so with no beat in flight; the block does not check.
// They reset to throttle 55, roll 445, pitch and yaw -445, 1000 ms both holds.
module stick_gesture_arming_fsm import sgaf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // config port
  input  logic                      cfg_we,
  input  logic [CIDX_W-1:0]         cfg_index,
  input  logic [CDATA_W-1:0]        cfg_wdata,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic signed [STICK_W-1:0] in_throttle_stick,
  input  logic signed [STICK_W-1:0] in_roll_stick,
  input  logic signed [STICK_W-1:0] in_pitch_stick,
  input  logic signed [STICK_W-1:0] in_yaw_stick,
  input  logic [TIME_W-1:0]         in_now_ms,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_phase,
  output logic                      out_is_armed
);

  cfg_t              cfg;
  // input register
  logic              s1_valid_r;
  kind_t             s1_kind_r;
  sticks_t           s1_sticks_r;
  logic [TIME_W-1:0] s1_now_r;
  // result register
  logic              out_valid_r;
  fsm_res_t          out_res_r;

  logic     s1_adv;   // input register may move into the result register
  logic     gesture;
  fsm_req_t fsm_req;
  fsm_res_t fsm_res;

  sgaf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // result register frees up when empty or being taken this cycle
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r            <= kind_t'(in_kind);
      s1_sticks_r.throttle <= in_throttle_stick;
      s1_sticks_r.roll     <= in_roll_stick;
      s1_sticks_r.pitch    <= in_pitch_stick;
      s1_sticks_r.yaw      <= in_yaw_stick;
      s1_now_r             <= in_now_ms;
    end
  end

  sgaf_gesture u_gesture (
    .sticks_i  (s1_sticks_r),
    .cfg_i     (cfg),
    .gesture_o (gesture)
  );

  // the fsm state commits exactly when the beat moves to the result register
  assign fsm_req.step    = s1_valid_r && s1_adv;
  assign fsm_req.kind    = s1_kind_r;
  assign fsm_req.gesture = gesture;
  assign fsm_req.now_ms  = s1_now_r;

  sgaf_phase_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (fsm_req),
    .cfg_i (cfg),
    .res_o (fsm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm_req.step) begin
      out_res_r <= fsm_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_phase    = out_res_r.phase;
  assign out_is_armed = out_res_r.is_armed;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted beat not held in input register");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv |=> out_valid_r)
    else $error("beat lost between input and result register");

  a_armed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.is_armed == (out_res_r.phase == PH_ARMED ||
      out_res_r.phase == PH_DISARMING || out_res_r.phase == PH_DISARM_STANDBY ||
      out_res_r.phase == PH_DEBUG))
    else $error("armed flag disagrees with phase");
`endif

endmodule

// File: rtl/core/sgaf_cfg_regs.sv
// ----------------------------------------------------------------------------
// sgaf_cfg_regs
// Write-only configuration registers for gesture limits and hold times.
// ----------------------------------------------------------------------------
module sgaf_cfg_regs import sgaf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_wdata,
  output cfg_t               cfg_o
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_max   <= RST_THROTTLE_MAX;
      cfg_r.roll_min       <= RST_ROLL_MIN;
      cfg_r.pitch_max      <= RST_PITCH_MAX;
      cfg_r.yaw_max        <= RST_YAW_MAX;
      cfg_r.arm_hold_ms    <= RST_ARM_HOLD;
      cfg_r.disarm_hold_ms <= RST_DISARM_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THROTTLE_MAX: cfg_r.throttle_max   <= cfg_wdata[STICK_W-1:0];
        CFG_ROLL_MIN:     cfg_r.roll_min       <= cfg_wdata[STICK_W-1:0];
        CFG_PITCH_MAX:    cfg_r.pitch_max      <= cfg_wdata[STICK_W-1:0];
        CFG_YAW_MAX:      cfg_r.yaw_max        <= cfg_wdata[STICK_W-1:0];
        CFG_ARM_HOLD:     cfg_r.arm_hold_ms    <= cfg_wdata[TIME_W-1:0];
        CFG_DISARM_HOLD:  cfg_r.disarm_hold_ms <= cfg_wdata[TIME_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/core/sgaf_gesture.sv
// ----------------------------------------------------------------------------
// sgaf_gesture
// Signed compare of the four sticks against the configured gesture window.
// ----------------------------------------------------------------------------
module sgaf_gesture import sgaf_pkg::*; (
  input  sticks_t sticks_i,
  input  cfg_t    cfg_i,
  output logic    gesture_o
);

  logic thr_ok, roll_ok, pitch_ok, yaw_ok;

  assign thr_ok    = (sticks_i.throttle <= cfg_i.throttle_max);
  assign roll_ok   = (sticks_i.roll     >= cfg_i.roll_min);
  assign pitch_ok  = (sticks_i.pitch    <= cfg_i.pitch_max);
  assign yaw_ok    = (sticks_i.yaw      <= cfg_i.yaw_max);
  assign gesture_o = thr_ok & roll_ok & pitch_ok & yaw_ok;

endmodule

// File: rtl/core/sgaf_phase_fsm.sv
// ----------------------------------------------------------------------------
// sgaf_phase_fsm
// Arm / disarm phase machine with hold-start timestamp.
// ----------------------------------------------------------------------------
module sgaf_phase_fsm import sgaf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fsm_req_t req_i,
  input  cfg_t     cfg_i,
  output fsm_res_t res_o
);

  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] hold_start_r, hold_start_nxt;
  logic [TIME_W-1:0] elapsed;

  // wrapping difference
  assign elapsed = req_i.now_ms - hold_start_r;

  always_comb begin
    phase_nxt      = phase_r;
    hold_start_nxt = hold_start_r;
    if (req_i.kind == KIND_DEBUG) begin
      phase_nxt = PH_DEBUG;
    end else begin
      unique case (phase_r)
        PH_ARMED: begin
          if (req_i.gesture) begin
            phase_nxt      = PH_DISARMING;
            hold_start_nxt = req_i.now_ms;
          end
        end
        PH_DISARMED: begin
          if (req_i.gesture) begin
            phase_nxt      = PH_ARMING;
            hold_start_nxt = req_i.now_ms;
          end
        end
        PH_DISARMING: begin
          if (!req_i.gesture) begin
            phase_nxt = PH_ARMED;
          end else if (elapsed > cfg_i.disarm_hold_ms) begin
            phase_nxt = PH_DISARM_STANDBY;
          end
        end
        PH_DISARM_STANDBY: begin
          if (!req_i.gesture) phase_nxt = PH_DISARMED;
        end
        PH_ARMING: begin
          if (!req_i.gesture) begin
            phase_nxt = PH_DISARMED;
          end else if (elapsed > cfg_i.arm_hold_ms) begin
            phase_nxt = PH_ARM_STANDBY;
          end
        end
        PH_ARM_STANDBY: begin
          if (!req_i.gesture) phase_nxt = PH_ARMED;
        end
        default: begin
          // debug and the unused code fall back to disarmed
          phase_nxt = PH_DISARMED;
        end
      endcase
    end
  end

  // result describes the phase after this item
  always_comb begin
    res_o.phase = phase_nxt;
    unique case (phase_nxt)
      PH_ARMED, PH_DISARMING, PH_DISARM_STANDBY, PH_DEBUG: res_o.is_armed = 1'b1;
      default:                                             res_o.is_armed = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DISARMED;
      hold_start_r <= '0;
    end else if (req_i.step) begin
      phase_r      <= phase_nxt;
      hold_start_r <= hold_start_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !req_i.step |=> $stable(phase_r) && $stable(hold_start_r))
    else $error("fsm state moved without an item");

  a_debug_enter: assert property (@(posedge clk) disable iff (!rst_n)
    req_i.step && req_i.kind == KIND_DEBUG |=> phase_r == PH_DEBUG)
    else $error("debug item did not enter debug phase");

  a_hold_start_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && hold_start_r != $past(hold_start_r) |->
      $past(phase_r) == PH_DISARMED || $past(phase_r) == PH_ARMED)
    else $error("hold start changed outside a stable phase");

  a_release_arming: assert property (@(posedge clk) disable iff (!rst_n)
    req_i.step && req_i.kind == KIND_UPDATE && !req_i.gesture &&
      phase_r == PH_ARMING |=> phase_r == PH_DISARMED)
    else $error("early release while arming did not revert");
`endif

endmodule
